// File: design/sorted_priority_queue_unit_macros.svh
// Assertion macros for the sorted priority queue unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/spq_pkg.sv
// Package for the sorted priority queue unit: sizes, request codes, lane types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

	localparam int DEPTH         = 16;
	localparam int VALUE_W       = 32;
	localparam int KIND_W        = 2;
	localparam int POS_W         = $clog2(DEPTH);
	localparam int CNT_W         = $clog2(DEPTH + 1);
	localparam int MATCH_POS_W   = 4;
	localparam int ENTRY_COUNT_W = 5;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      valid;
		logic                      le;
		logic                      hit;
	} lane_t;

	typedef struct packed {
		logic                      cap;
		logic signed [VALUE_W-1:0] cmp_key;
		logic                      ins;
		logic                      rem;
		logic signed [VALUE_W-1:0] ins_key;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/spq_cell.sv
// One slot of the sorted queue: value, valid bit, compare flags, shift mux.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  spq_pkg::cell_ctrl_t           ctrl,
	input  spq_pkg::lane_t                left,
	input  spq_pkg::lane_t                right,
	output spq_pkg::lane_t                lane,
	output logic                          first,
	output logic signed [spq_pkg::VALUE_W-1:0] nxt_value,
	output logic                          nxt_valid
);
	import spq_pkg::*;

	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_q;
	logic                      le_q;
	logic                      eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			le_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
			if (ctrl.cap) begin
				le_q <= valid_q && (value_q <= ctrl.cmp_key);
				eq_q <= valid_q && (value_q == ctrl.cmp_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= nxt_value;
	end

	always_comb begin
		nxt_value = value_q;
		nxt_valid = valid_q;
		if (ctrl.ins) begin
			if (!le_q) begin
				nxt_value = left.le ? ctrl.ins_key : left.value;
				nxt_valid = left.valid;
			end
		end else if (ctrl.rem && (left.hit || eq_q)) begin
			nxt_value = right.value;
			nxt_valid = right.valid;
		end
	end

	assign first      = eq_q & ~left.hit;
	assign lane.value = value_q;
	assign lane.valid = valid_q;
	assign lane.le    = le_q;
	assign lane.hit   = left.hit | eq_q;

endmodule
`default_nettype wire

// File: design/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: request control, cell chain, result registers.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_unit_macros.svh.
// After accept the request passes the shift state (ST_SHIFT); done and the results are registered from it.
// No new request is accepted while busy in the shift state; cells compare at accept, then shift together.
// Reset: arst_n clears all valid bits, the count and control; the queue starts empty.
// The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_unit_macros.svh"
module sorted_priority_queue_unit (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    start,
	output logic                                   busy,
	input  wire  [spq_pkg::KIND_W-1:0]             kind,
	input  wire  signed [spq_pkg::VALUE_W-1:0]     value,
	output logic                                   done,
	output logic                                   success,
	output logic                                   overflow,
	output logic [spq_pkg::MATCH_POS_W-1:0]        match_position,
	output logic signed [spq_pkg::VALUE_W-1:0]     head_value,
	output logic                                   head_valid,
	output logic [spq_pkg::ENTRY_COUNT_W-1:0]      entry_count
);
	import spq_pkg::*;

	localparam logic [0:0] ST_IDLE  = 1'b0;
	localparam logic [0:0] ST_SHIFT = 1'b1;

	logic [0:0]                state_q;
	logic [KIND_W-1:0]         kind_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [CNT_W-1:0]          count_q;
	logic                      accept;
	logic                      full;
	logic                      any_hit;
	logic                      is_ins;
	logic                      is_look;
	logic [POS_W-1:0]          pos_enc;
	logic [CNT_W-1:0]          count_d;
	cell_ctrl_t                ctrl;

	lane_t                     lanes [DEPTH];
	lane_t                     left_in [DEPTH];
	lane_t                     right_in [DEPTH];
	logic [DEPTH-1:0]          first;
	logic signed [VALUE_W-1:0] nxt_value [DEPTH];
	logic [DEPTH-1:0]          nxt_valid;

	logic                      done_q;
	logic                      success_q;
	logic                      overflow_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [VALUE_W-1:0] head_value_q;
	logic                      head_valid_q;

	assign busy   = (state_q == ST_SHIFT);
	assign accept = start & ~busy;
	assign full   = (count_q == CNT_W'(DEPTH));

	always_comb begin
		is_ins  = 1'b0;
		is_look = 1'b0;
		unique case (kind_q) inside
			KIND_INSERT: is_ins = 1'b1;
			KIND_REMOVE, KIND_FIND: is_look = 1'b1;
			default: ;
		endcase
	end

	assign any_hit      = lanes[DEPTH-1].hit;
	assign ctrl.cap     = accept;
	assign ctrl.cmp_key = value;
	assign ctrl.ins     = busy & is_ins & ~full;
	assign ctrl.rem     = busy & (kind_q == KIND_REMOVE) & any_hit;
	assign ctrl.ins_key = key_q;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign left_in[g] = '{value: '0, valid: 1'b1, le: 1'b1, hit: 1'b0};
			end else begin : g_mid
				assign left_in[g] = lanes[g-1];
			end
			if (g == DEPTH - 1) begin : g_tail
				assign right_in[g] = '{value: '0, valid: 1'b0, le: 1'b0, hit: 1'b0};
			end else begin : g_body
				assign right_in[g] = lanes[g+1];
			end
			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.left      (left_in[g]),
				.right     (right_in[g]),
				.lane      (lanes[g]),
				.first     (first[g]),
				.nxt_value (nxt_value[g]),
				.nxt_valid (nxt_valid[g])
			);
		end
	endgenerate

	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				pos_enc = pos_enc | POS_W'(i);
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					state_q <= ST_IDLE;
					count_q <= count_d;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= value;
		end
		if (busy) begin
			success_q    <= ctrl.ins | (is_look & any_hit);
			overflow_q   <= is_ins & full;
			pos_q        <= (is_look & any_hit) ? pos_enc : '0;
			head_valid_q <= nxt_valid[0];
			head_value_q <= nxt_valid[0] ? nxt_value[0] : '0;
		end
	end

	assign done           = done_q;
	assign success        = success_q;
	assign overflow       = overflow_q;
	assign match_position = MATCH_POS_W'(pos_q);
	assign head_value     = head_value_q;
	assign head_valid     = head_valid_q;
	assign entry_count    = ENTRY_COUNT_W'(count_q);

	`SPQ_ASSERT_NEXT(a_accept_then_busy, accept, busy && !done, "accepted request did not enter shift")
	`SPQ_ASSERT_NEXT(a_busy_then_done, busy, done && !busy, "shift cycle gave no result strobe")
	`SPQ_ASSERT_SAME(a_ovf_excl, done && overflow, !success && count_q == CNT_W'(DEPTH), "overflow with success or not full")
	`SPQ_ASSERT_SAME(a_head_count, done, head_valid == (count_q != '0) && nxt_valid[0] == head_valid, "head valid disagrees with count")

endmodule
`default_nettype wire
